[sv/kwc_pkg.sv]
`timescale 1ns / 1ps

package kwc_pkg;

  // Alphabet geometry
  localparam int ALPHA_SIZE = 26;
  localparam int LETTER_W   = 5;
  localparam int CHAR_W     = 8;
  localparam int REQ_W      = 2;

  localparam logic [CHAR_W-1:0] UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z = 8'h7A;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CHAR_W-1:0]   char_t;

  // Request codes; code 3 is unused and does nothing
  typedef enum logic [REQ_W-1:0] {
    REQ_BEGIN_KEY = 2'd0,
    REQ_KEY_CHAR  = 2'd1,
    REQ_MSG_CHAR  = 2'd2
  } req_t;

  // Decoded character
  typedef struct packed {
    logic    is_letter;
    logic    is_upper;
    letter_t idx;
  } letter_info_t;

  // Key state update request from the datapath to the key store
  typedef struct packed {
    logic    begin_key;
    logic    add_letter;
    letter_t idx;
  } key_upd_t;

  function automatic letter_info_t decode_char(input char_t c);
    letter_info_t info;
    char_t        diff;
    info.is_upper = 1'b0;
    info.is_letter = 1'b0;
    diff = '0;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      info.is_letter = 1'b1;
      info.is_upper  = 1'b1;
      diff = c - UPPER_A;
    end else if (c >= LOWER_A && c <= LOWER_Z) begin
      info.is_letter = 1'b1;
      diff = c - LOWER_A;
    end
    info.idx = diff[LETTER_W-1:0];
    return info;
  endfunction

endpackage

[sv/keyword_substitution_cipher_top.sv]
`timescale 1ns / 1ps

// Channel | Ports                                       | Direction
// --------+---------------------------------------------+----------
// input   | in_valid, in_stall, in_req_type, in_char_code | request in
// result  | out_valid, out_stall, out_char              | result out
//
// One request per cycle while in_stall is low; a message character's result passes
// the input register, then the lookup into the result register.
// Key requests update the key store as they leave the input register.
// Synchronous active-low reset clears the key (no letters seen, count zero).
// While out_stall holds a result, requests are still taken into the input
// register; in_stall rises only when that register holds a message character.

module keyword_substitution_cipher_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [kwc_pkg::REQ_W-1:0]           in_req_type,
  input  logic [kwc_pkg::CHAR_W-1:0]          in_char_code,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [kwc_pkg::CHAR_W-1:0]          out_char
);

  // Input register
  logic                        s1_valid_r, s1_valid_nxt;
  logic [kwc_pkg::REQ_W-1:0]   s1_type_r;
  kwc_pkg::char_t              s1_char_r;

  // Result register
  logic                        out_valid_r, out_valid_nxt;
  kwc_pkg::char_t              out_char_r, out_char_nxt;

  kwc_pkg::req_t               s1_req;
  kwc_pkg::letter_info_t       info;
  kwc_pkg::key_upd_t           upd;
  kwc_pkg::letter_t            sub_letter;
  logic                        needs_out;
  logic                        out_free;
  logic                        s1_go;
  logic                        in_take;
  kwc_pkg::char_t              enc_char;

  assign s1_req = kwc_pkg::req_t'(s1_type_r);
  assign info   = kwc_pkg::decode_char(s1_char_r);

  // Request classification
  always_comb begin
    needs_out      = 1'b0;
    upd.begin_key  = 1'b0;
    upd.add_letter = 1'b0;
    upd.idx        = info.idx;
    unique case (s1_req)
      kwc_pkg::REQ_BEGIN_KEY: upd.begin_key  = s1_go;
      kwc_pkg::REQ_KEY_CHAR:  upd.add_letter = s1_go && info.is_letter;
      kwc_pkg::REQ_MSG_CHAR:  needs_out      = s1_valid_r;
      default: ;
    endcase
  end

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!needs_out || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  kwc_key_store u_key_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (upd),
    .lookup_idx (info.idx),
    .sub_letter (sub_letter)
  );

  // Enciphered byte, case kept; non-letters pass through
  always_comb begin
    if (!info.is_letter) begin
      enc_char = s1_char_r;
    end else if (info.is_upper) begin
      enc_char = kwc_pkg::UPPER_A + kwc_pkg::char_t'(sub_letter);
    end else begin
      enc_char = kwc_pkg::LOWER_A + kwc_pkg::char_t'(sub_letter);
    end
  end

  // Next state of the two registers
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    if (out_free) begin
      out_valid_nxt = needs_out;
      if (needs_out) begin
        out_char_nxt = enc_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_type_r <= in_req_type;
      s1_char_r <= in_char_code;
    end
    out_char_r <= out_char_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;

endmodule

[sv/kwc_key_store.sv]
`timescale 1ns / 1ps

module kwc_key_store (
  input  logic              clk,
  input  logic              rst_n,
  input  kwc_pkg::key_upd_t upd,
  input  kwc_pkg::letter_t  lookup_idx,
  output kwc_pkg::letter_t  sub_letter
);

  logic [kwc_pkg::ALPHA_SIZE-1:0] seen_mask_r, seen_mask_nxt;
  kwc_pkg::letter_t               key_count_r, key_count_nxt;
  // Number of unseen letters below each letter position
  kwc_pkg::letter_t               zero_below_r [kwc_pkg::ALPHA_SIZE];
  kwc_pkg::letter_t               zero_below_nxt [kwc_pkg::ALPHA_SIZE];
  // Ordered key list, no reset
  kwc_pkg::letter_t               key_list_r [kwc_pkg::ALPHA_SIZE];

  logic                           do_add;
  kwc_pkg::letter_t               rank;
  logic [kwc_pkg::ALPHA_SIZE-1:0] hit;
  kwc_pkg::letter_t               sel_letter;

  // A key letter is added only once and only while the list has room
  assign do_add = upd.add_letter && !seen_mask_r[upd.idx] &&
                  (key_count_r < kwc_pkg::letter_t'(kwc_pkg::ALPHA_SIZE));

  // Next key state
  always_comb begin
    seen_mask_nxt = seen_mask_r;
    key_count_nxt = key_count_r;
    for (int b = 0; b < kwc_pkg::ALPHA_SIZE; b++) begin
      zero_below_nxt[b] = zero_below_r[b];
    end
    if (upd.begin_key) begin
      seen_mask_nxt = '0;
      key_count_nxt = '0;
      for (int b = 0; b < kwc_pkg::ALPHA_SIZE; b++) begin
        zero_below_nxt[b] = kwc_pkg::letter_t'(b);
      end
    end else if (do_add) begin
      seen_mask_nxt[upd.idx] = 1'b1;
      key_count_nxt = key_count_r + kwc_pkg::letter_t'(1);
      // Every position above the new letter loses one unseen letter below it
      for (int b = 0; b < kwc_pkg::ALPHA_SIZE; b++) begin
        if (kwc_pkg::letter_t'(b) > upd.idx) begin
          zero_below_nxt[b] = zero_below_r[b] - kwc_pkg::letter_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_mask_r <= '0;
      key_count_r <= '0;
      for (int b = 0; b < kwc_pkg::ALPHA_SIZE; b++) begin
        zero_below_r[b] <= kwc_pkg::letter_t'(b);
      end
    end else begin
      seen_mask_r <= seen_mask_nxt;
      key_count_r <= key_count_nxt;
      for (int b = 0; b < kwc_pkg::ALPHA_SIZE; b++) begin
        zero_below_r[b] <= zero_below_nxt[b];
      end
    end
  end

  // Key list write at the current count
  always_ff @(posedge clk) begin
    if (do_add && !upd.begin_key) begin
      key_list_r[key_count_r] <= upd.idx;
    end
  end

  // Rank-select: the unseen letter whose count of unseen letters below equals rank
  assign rank = lookup_idx - key_count_r;

  always_comb begin
    sel_letter = '0;
    for (int b = 0; b < kwc_pkg::ALPHA_SIZE; b++) begin
      hit[b] = !seen_mask_r[b] && (zero_below_r[b] == rank);
      if (hit[b]) begin
        sel_letter = sel_letter | kwc_pkg::letter_t'(b);
      end
    end
  end

  // Key entry for low indexes, rank-select for the rest
  assign sub_letter = (lookup_idx < key_count_r) ? key_list_r[lookup_idx] : sel_letter;

endmodule
